// ===== rtl/core/pfd_pkg.sv =====
package pfd_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOTS_MAX     = 1024;
   localparam int SLOT_IDX_W    = 10;
   localparam int COUNT_W       = 11;
   localparam int CAP_W         = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [1:0] REQ_SET        = 2'd0;
   localparam logic [1:0] REQ_GET        = 2'd1;
   localparam logic [1:0] REQ_CLEAR_ONE  = 2'd2;
   localparam logic [1:0] REQ_CLEAR_PROC = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_PID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] process_id;
      logic [31:0] descriptor;
      logic [63:0] payload_in;
   } pfd_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        hit;
      logic [5:0]  slot_index;
      logic [63:0] payload_out;
      logic [6:0]  cleared_count;
   } pfd_rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [1:0]            req;
      logic [31:0]           pid;
      logic [31:0]           fd;
      logic [63:0]           payload;
      logic                  found;
      logic [SLOT_IDX_W-1:0] slot;
      logic                  free_found;
      logic [SLOT_IDX_W-1:0] free_idx;
      logic [COUNT_W-1:0]    count;
      logic [63:0]           pout;
   } pfd_token_type;

   typedef struct packed {
      logic                  valid;
      logic [SLOT_IDX_W-1:0] idx;
      logic [31:0]           pid;
      logic [31:0]           fd;
      logic [63:0]           payload;
   } pfd_alloc_type;

endpackage

// ===== rtl/core/pfd_cell.sv =====
module pfd_cell #(
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [pfd_pkg::CAP_W-1:0] capacity,
   input  pfd_pkg::pfd_alloc_type    alloc,
   input  pfd_pkg::pfd_token_type    tok_in,
   output pfd_pkg::pfd_token_type    tok_out
);
   import pfd_pkg::*;

   localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(INDEX);

   logic          valid_ff, valid_in;
   logic [31:0]   pid_ff, pid_in;
   logic [31:0]   fd_ff, fd_in;
   logic [63:0]   payload_ff, payload_in;
   pfd_token_type tok_ff, tok_in_nx;

   logic active, key_hit, first, frees, alloc_hit;

   always_comb begin
      active    = tok_in.valid && (32'(capacity) > 32'(INDEX));
      key_hit   = active && valid_ff && (pid_ff == tok_in.pid) &&
                  ((tok_in.req == REQ_CLEAR_PROC) || (fd_ff == tok_in.fd));
      first     = key_hit && !tok_in.found;
      frees     = key_hit && ((tok_in.req == REQ_CLEAR_PROC) ||
                              (first && (tok_in.req == REQ_CLEAR_ONE)));
      alloc_hit = alloc.valid && (alloc.idx == MY_IDX);

      tok_in_nx = tok_in;
      if (key_hit) begin
         tok_in_nx.found = 1'b1;
      end
      if (first) begin
         tok_in_nx.slot = MY_IDX;
      end
      if (first && (tok_in.req == REQ_GET)) begin
         tok_in_nx.pout = payload_ff;
      end
      if (frees) begin
         tok_in_nx.count = tok_in.count + COUNT_W'(1);
      end
      if (active && !valid_ff && !tok_in.free_found) begin
         tok_in_nx.free_found = 1'b1;
         tok_in_nx.free_idx   = MY_IDX;
      end

      valid_in   = valid_ff;
      pid_in     = pid_ff;
      fd_in      = fd_ff;
      payload_in = payload_ff;
      if (alloc_hit) begin
         valid_in   = 1'b1;
         pid_in     = alloc.pid;
         fd_in      = alloc.fd;
         payload_in = alloc.payload;
      end else if (frees) begin
         valid_in = 1'b0;
      end else if (first && (tok_in.req == REQ_SET)) begin
         payload_in = tok_in.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pid_ff     <= pid_in;
         fd_ff      <= fd_in;
         payload_ff <= payload_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/process_fd_path_table.sv =====
// Associative table of SLOTS entries keyed by (process id, descriptor), each holding
// a 64-bit path handle. Every request, including one with process id zero, travels
// down a row of SLOTS cells, one cell per cycle while the row is not held, and its
// single result lands in the output register as it leaves the last cell; the next
// request is taken once the previous one has left the last cell. A result waiting
// on rsp_ready holds the row, once the next request reaches the last cell, until it
// is taken. The capacity register limits searching and allocation to the lowest
// slots and must only be written while no request is in flight. All entries are
// invalid after reset, with no clearing pass.
module process_fd_path_table #(
   parameter int SLOTS = pfd_pkg::SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pfd_pkg::pfd_req_type      req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pfd_pkg::pfd_rsp_type      rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [pfd_pkg::CAP_W-1:0] csr_wr_data
);
   import pfd_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   pfd_rsp_type      rsp_ff, rsp_in;

   pfd_token_type    launch;
   pfd_token_type    chain [SLOTS];
   pfd_token_type    tail;
   pfd_alloc_type    alloc;
   logic             advance, accept, retire;

   assign tail      = chain[SLOTS-1];
   assign advance   = !(tail.valid && rsp_valid_ff && !rsp_ready);
   assign retire    = tail.valid && advance;
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      launch            = '0;
      launch.valid      = accept;
      launch.req        = req_payload.req_type;
      launch.pid        = req_payload.process_id;
      launch.fd         = req_payload.descriptor;
      launch.payload    = req_payload.payload_in;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      pfd_token_type cell_in;
      if (i == 0) begin : g_head
         assign cell_in = launch;
      end else begin : g_link
         assign cell_in = chain[i-1];
      end
      pfd_cell #(.INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .capacity (cap_ff),
         .alloc    (alloc),
         .tok_in   (cell_in),
         .tok_out  (chain[i])
      );
   end

   always_comb begin
      rsp_in        = '0;
      alloc         = '0;
      alloc.idx     = tail.free_idx;
      alloc.pid     = tail.pid;
      alloc.fd      = tail.fd;
      alloc.payload = tail.payload;
      if (tail.pid == 32'd0) begin
         rsp_in.status = ST_BAD_PID;
      end else if (tail.found) begin
         rsp_in.status        = ST_OK;
         rsp_in.hit           = 1'b1;
         rsp_in.slot_index    = tail.slot[5:0];
         rsp_in.payload_out   = tail.pout;
         rsp_in.cleared_count = tail.count[6:0];
      end else if (tail.req == REQ_SET) begin
         if (tail.free_found) begin
            rsp_in.status     = ST_OK;
            rsp_in.slot_index = tail.free_idx[5:0];
            alloc.valid       = retire;
         end else begin
            rsp_in.status = ST_FULL;
         end
      end else begin
         rsp_in.status = ST_MISSING;
      end

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (retire) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
